// ===== rtl/invalidation_tag_tracker_core_assert.svh =====
// Assertion macros used by the tracker core RTL.
`ifndef INVALIDATION_TAG_TRACKER_CORE_ASSERT_SVH
`define INVALIDATION_TAG_TRACKER_CORE_ASSERT_SVH

// Checked outside reset.
`define ITT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ITT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/itt_pkg.sv =====
package itt_pkg;

    localparam int NUM_TAGS    = 2;
    localparam int TAG_W       = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int CNT_W       = 3;
    localparam int SEG_W       = 8;
    localparam int RID_W       = 16;
    localparam int MASK_W      = 32;
    localparam int TAG_INDEX_W = 5;

    // Response counts wrap modulo eight.
    localparam logic [CNT_W-1:0] CNT_MASK = 3'h7;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_COMPL  = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             seg_valid;
        logic [SEG_W-1:0] segment;
        logic [RID_W-1:0] requester;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        t_entry           entry;
        logic             busy;
        logic             seg_valid;
        logic [SEG_W-1:0] segment;
        logic [RID_W-1:0] requester;
        logic [CNT_W-1:0] done_count;
    } t_check_req;

    typedef struct packed {
        logic             mismatch;
        logic [CNT_W-1:0] next_count;
        logic             retire;
    } t_check_rsp;

endpackage

// ===== rtl/itt_tag_check.sv =====
module itt_tag_check
    import itt_pkg::*;
(
    input  t_check_req i_req,
    output t_check_rsp o_rsp
);

    logic seg_bad;

    // A tag that carries a segment only answers a request with the same segment.
    assign seg_bad = i_req.entry.seg_valid &&
                     (!i_req.seg_valid || (i_req.segment != i_req.entry.segment));

    assign o_rsp.mismatch   = !i_req.busy || seg_bad ||
                              (i_req.entry.requester != i_req.requester);
    assign o_rsp.next_count = (i_req.entry.count + 1'b1) & CNT_MASK;
    assign o_rsp.retire     = (o_rsp.next_count == i_req.done_count);

endmodule

// ===== rtl/invalidation_tag_tracker_core.sv =====
// Invalidation tag tracker.
// Input channel (i_in_valid / o_in_ready) carries one command per transaction:
// allocate a tag, report an invalidation completion against masked tags, or
// expire masked tags on a timer. Output channel (o_out_valid / i_out_ready)
// returns exactly one result per command: status, allocated tag index, whether
// any tag is still busy, and the sticky timeout flag.
// A sequencer walks the tags one per cycle through a single shared check unit,
// so a command passes an accept step, a scan of up to NUM_TAGS tags (2 here) and
// a finish step that loads the result: o_out_valid rises when the result is
// loaded, when o_in_ready returns as well; a new command is taken only after
// the previous one has left the finish step. Allocation stops at the first
// free tag; a completion stops at the first mismatch.
// Each finished result sits in an output register, so a new command is taken
// while the previous result still waits; if the receiver stalls, the next
// result waits in the finish step until the output register frees up.
// Reset (i_rst_n low, synchronous) frees every tag, clears the timeout flag
// and empties the output register. Tag contents are written by allocation; completions update their counts.
module invalidation_tag_tracker_core
    import itt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_cmd,
    input  logic                   i_seg_valid,
    input  logic [SEG_W-1:0]       i_segment,
    input  logic [RID_W-1:0]       i_requester_id,
    input  logic [MASK_W-1:0]      i_tag_mask,
    input  logic [CNT_W-1:0]       i_done_count,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_status,
    output logic [TAG_INDEX_W-1:0] o_tag_index,
    output logic                   o_any_pending,
    output logic                   o_timed_out
);

    `include "invalidation_tag_tracker_core_assert.svh"

    t_state                r_state, n_state;
    logic [TAG_W-1:0]      r_idx, n_idx;
    logic                  r_status, n_status;
    logic [TAG_W-1:0]      r_alloc_idx, n_alloc_idx;
    logic [NUM_TAGS-1:0]   r_busy, n_busy;
    logic                  r_timeout, n_timeout;

    t_cmd                  r_cmd;
    logic                  r_sv;
    logic [SEG_W-1:0]      r_seg;
    logic [RID_W-1:0]      r_rid;
    logic [NUM_TAGS-1:0]   r_mask;
    logic [CNT_W-1:0]      r_cc;

    t_entry                r_entry [NUM_TAGS];

    logic                  r_out_valid;
    logic                  r_o_status;
    logic [TAG_INDEX_W-1:0] r_o_idx;
    logic                  r_o_pending;
    logic                  r_o_timed;

    logic                  load_req;
    logic                  load_out;
    logic                  entry_we;
    t_entry                entry_wdata;
    logic                  last_tag;
    t_check_req            chk_req;
    t_check_rsp            chk_rsp;

    assign last_tag = (r_idx == TAG_W'(NUM_TAGS - 1));

    assign chk_req.entry      = r_entry[r_idx];
    assign chk_req.busy       = r_busy[r_idx];
    assign chk_req.seg_valid  = r_sv;
    assign chk_req.segment    = r_seg;
    assign chk_req.requester  = r_rid;
    assign chk_req.done_count = r_cc;

    itt_tag_check u_check (
        .i_req (chk_req),
        .o_rsp (chk_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_status    = r_status;
        n_alloc_idx = r_alloc_idx;
        n_busy      = r_busy;
        n_timeout   = r_timeout;
        load_req    = 1'b0;
        load_out    = 1'b0;
        entry_we    = 1'b0;
        entry_wdata = r_entry[r_idx];
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    load_req    = 1'b1;
                    n_idx       = '0;
                    n_status    = 1'b0;
                    n_alloc_idx = '0;
                    n_state     = (t_cmd'(i_cmd) == CMD_NOP) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (!r_busy[r_idx]) begin
                            n_busy[r_idx]         = 1'b1;
                            entry_we              = 1'b1;
                            entry_wdata.seg_valid = r_sv;
                            entry_wdata.segment   = r_seg;
                            entry_wdata.requester = r_rid;
                            entry_wdata.count     = '0;
                            n_alloc_idx           = r_idx;
                            n_state               = ST_FINISH;
                        end else if (last_tag) begin
                            n_status = 1'b1;
                            n_state  = ST_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    CMD_COMPL: begin
                        if (r_mask[r_idx] && chk_rsp.mismatch) begin
                            // Tags already walked keep their updates.
                            n_status = 1'b1;
                            n_state  = ST_FINISH;
                        end else begin
                            if (r_mask[r_idx]) begin
                                entry_we          = 1'b1;
                                entry_wdata.count = chk_rsp.next_count;
                                if (chk_rsp.retire) begin
                                    n_busy[r_idx] = 1'b0;
                                end
                            end
                            if (last_tag) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end
                    CMD_EXPIRE: begin
                        if (r_mask[r_idx]) begin
                            n_busy[r_idx] = 1'b0;
                        end
                        if (last_tag) begin
                            n_timeout = 1'b1;
                            n_state   = ST_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_status    <= 1'b0;
            r_alloc_idx <= '0;
            r_busy      <= '0;
            r_timeout   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_status    <= n_status;
            r_alloc_idx <= n_alloc_idx;
            r_busy      <= n_busy;
            r_timeout   <= n_timeout;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_sv   <= i_seg_valid;
            r_seg  <= i_segment;
            r_rid  <= i_requester_id;
            r_mask <= i_tag_mask[NUM_TAGS-1:0];
            r_cc   <= i_done_count;
        end
        if (entry_we) begin
            r_entry[r_idx] <= entry_wdata;
        end
        if (load_out) begin
            r_o_status  <= r_status;
            r_o_idx     <= TAG_INDEX_W'(r_alloc_idx);
            r_o_pending <= |r_busy;
            r_o_timed   <= r_timeout;
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_tag_index   = r_o_idx;
    assign o_any_pending = r_o_pending;
    assign o_timed_out   = r_o_timed;

    `ITT_ASSERT(a_alloc_sets_busy,
        (r_state == ST_SCAN && r_cmd == CMD_ALLOC && !r_busy[r_idx]) |=> r_busy[$past(r_idx)],
        "allocated tag is not marked busy")
    `ITT_ASSERT(a_timeout_sticky, r_timeout |=> r_timeout,
        "timeout flag cleared outside reset")
    `ITT_ASSERT(a_busy_only_in_scan, (r_state != ST_SCAN) |=> $stable(r_busy),
        "tag busy bits changed outside a scan")
    `ITT_ASSERT_ALWAYS(a_fail_zero_index, (o_out_valid && o_status) |-> (o_tag_index == '0),
        "failed command reports a nonzero tag index")

endmodule

// ===== bench/invalidation_tag_tracker_core_test.sv =====
`timescale 1ns / 100ps

module invalidation_tag_tracker_core_test;
    import itt_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam logic [MASK_W-1:0] TAG_BITS = MASK_W'((64'd1 << NUM_TAGS) - 1);

    typedef struct packed {
        logic                   status;
        logic [TAG_INDEX_W-1:0] tag_index;
        logic                   any_pending;
        logic                   timed_out;
    } t_tracker_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_cmd          = '0;
    logic                   i_seg_valid    = 1'b0;
    logic [SEG_W-1:0]       i_segment      = '0;
    logic [RID_W-1:0]       i_requester_id = '0;
    logic [MASK_W-1:0]      i_tag_mask     = '0;
    logic [CNT_W-1:0]       i_done_count   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic                   o_status;
    logic [TAG_INDEX_W-1:0] o_tag_index;
    logic                   o_any_pending;
    logic                   o_timed_out;

    // Shadow copy of the tag table, advanced once per accepted transaction.
    logic             shadow_busy      [NUM_TAGS];
    logic             shadow_seg_valid [NUM_TAGS];
    logic [SEG_W-1:0] shadow_segment   [NUM_TAGS];
    logic [RID_W-1:0] shadow_requester [NUM_TAGS];
    logic [CNT_W-1:0] shadow_count     [NUM_TAGS];
    logic             shadow_timeout;

    t_tracker_result awaited_results[$];
    t_tracker_result want_res;
    int              error_count = 0;
    int              cycle_count = 0;
    int              burst_left  = 0;
    int              ready_mode  = 0;
    int              ready_phase = 0;

    invalidation_tag_tracker_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_seg_valid    (i_seg_valid),
        .i_segment      (i_segment),
        .i_requester_id (i_requester_id),
        .i_tag_mask     (i_tag_mask),
        .i_done_count   (i_done_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_tag_index    (o_tag_index),
        .o_any_pending  (o_any_pending),
        .o_timed_out    (o_timed_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("invalidation_tag_tracker_core_test NOT OK");
            $finish;
        end
    end

    // Receiver backpressure: phases of random length, each with its own stall pattern.
    always @(posedge i_clk) begin
        if (ready_phase == 0) begin
            ready_mode  <= $urandom_range(0, 3);
            ready_phase <= $urandom_range(10, 60);
        end else begin
            ready_phase <= ready_phase - 1;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (ready_phase % 4 == 0);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unrequested result", o_status, 0);
            end else begin
                want_res = awaited_results.pop_front();
                if (o_status !== want_res.status)
                    report_mismatch("status", o_status, want_res.status);
                if (o_tag_index !== want_res.tag_index)
                    report_mismatch("tag_index", o_tag_index, want_res.tag_index);
                if (o_any_pending !== want_res.any_pending)
                    report_mismatch("any_pending", o_any_pending, want_res.any_pending);
                if (o_timed_out !== want_res.timed_out)
                    report_mismatch("timed_out", o_timed_out, want_res.timed_out);
            end
        end
    end

    function automatic t_tracker_result apply_tag_command(
        input t_cmd             cmd,
        input logic             sv,
        input logic [SEG_W-1:0] seg,
        input logic [RID_W-1:0] rid,
        input logic [MASK_W-1:0] mask,
        input logic [CNT_W-1:0] cc
    );
        t_tracker_result res;
        int              t;
        bit              stopped;
        res     = '0;
        stopped = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                res.status = 1'b1;
                for (t = 0; t < NUM_TAGS; t++) begin
                    if (!stopped && !shadow_busy[t]) begin
                        shadow_busy[t]      = 1'b1;
                        shadow_seg_valid[t] = sv;
                        shadow_segment[t]   = seg;
                        shadow_requester[t] = rid;
                        shadow_count[t]     = '0;
                        res.tag_index       = TAG_INDEX_W'(t);
                        res.status          = 1'b0;
                        stopped             = 1'b1;
                    end
                end
            end
            CMD_COMPL: begin
                // The walk stops at the first bad tag; earlier tags keep their update.
                for (t = 0; t < NUM_TAGS; t++) begin
                    if (!stopped && mask[t]) begin
                        if (!shadow_busy[t] || shadow_requester[t] != rid ||
                            (shadow_seg_valid[t] && (!sv || seg != shadow_segment[t]))) begin
                            res.status = 1'b1;
                            stopped    = 1'b1;
                        end else begin
                            shadow_count[t] = shadow_count[t] + 1'b1;
                            if (shadow_count[t] == cc)
                                shadow_busy[t] = 1'b0;
                        end
                    end
                end
            end
            CMD_EXPIRE: begin
                for (t = 0; t < NUM_TAGS; t++)
                    if (mask[t])
                        shadow_busy[t] = 1'b0;
                shadow_timeout = 1'b1;
            end
            default: ;
        endcase
        for (t = 0; t < NUM_TAGS; t++)
            if (shadow_busy[t])
                res.any_pending = 1'b1;
        res.timed_out = shadow_timeout;
        return res;
    endfunction

    // Returns a random tag whose busy bit equals want_busy, or -1 if there is none.
    function automatic int find_tag(input logic want_busy);
        int start;
        int k;
        int found;
        found = -1;
        start = $urandom_range(0, NUM_TAGS - 1);
        for (k = 0; k < NUM_TAGS; k++)
            if (found < 0 && shadow_busy[(start + k) % NUM_TAGS] == want_busy)
                found = (start + k) % NUM_TAGS;
        return found;
    endfunction

    // Valid is left high when the burst goes on, so the next call only updates the payload.
    task automatic send_command(
        input t_cmd             cmd,
        input logic             sv,
        input logic [SEG_W-1:0] seg,
        input logic [RID_W-1:0] rid,
        input logic [MASK_W-1:0] mask,
        input logic [CNT_W-1:0] cc
    );
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_seg_valid    <= sv;
        i_segment      <= seg;
        i_requester_id <= rid;
        i_tag_mask     <= mask;
        i_done_count   <= cc;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_results.push_back(apply_tag_command(cmd, sv, seg, rid, mask, cc));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_allocation();
        send_command(CMD_ALLOC, 1'b1, 8'hFF, 16'hFFFF, 32'h0000_0000, 3'h7);
        send_command(CMD_ALLOC, 1'b0, 8'h00, 16'h0000, 32'hFFFF_FFFF, 3'h0);
        // Both tags are taken, so this one has to fail.
        send_command(CMD_ALLOC, 1'b1, 8'hA5, 16'h5A5A, 32'h0000_0000, 3'h0);
    endtask

    task automatic test_completion();
        send_command(CMD_COMPL, 1'b1, 8'hFF, 16'hFFFF, 32'h0000_0000, 3'h0);
        send_command(CMD_COMPL, 1'b0, 8'h00, 16'h0000, 32'h0000_0002, 3'h1);
        send_command(CMD_COMPL, 1'b0, 8'hFF, 16'hFFFF, 32'h0000_0001, 3'h0);
        send_command(CMD_COMPL, 1'b1, 8'hFE, 16'hFFFF, 32'h0000_0001, 3'h0);
        send_command(CMD_COMPL, 1'b1, 8'hFF, 16'hFFFE, 32'h0000_0001, 3'h0);
        // Tag 0 is counted, then the walk hits the free tag 1 and stops.
        send_command(CMD_COMPL, 1'b1, 8'hFF, 16'hFFFF, 32'h0000_0003, 3'h0);
        send_command(CMD_COMPL, 1'b1, 8'h00, 16'h0000, 32'hFFFF_FFFC, 3'h0);
        // A done count of zero means eight responses; tag 0 already has one.
        repeat (7)
            send_command(CMD_COMPL, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFD, 3'h0);
    endtask

    task automatic test_unused_command();
        send_command(CMD_NOP, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 3'h7);
    endtask

    task automatic test_timer_expiry();
        send_command(CMD_ALLOC, 1'b0, 8'h12, 16'h1234, 32'h0000_0000, 3'h0);
        send_command(CMD_ALLOC, 1'b1, 8'h34, 16'h4321, 32'h0000_0000, 3'h0);
        send_command(CMD_EXPIRE, 1'b0, 8'h00, 16'h0000, 32'h0000_0000, 3'h0);
        send_command(CMD_EXPIRE, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFE, 3'h7);
        send_command(CMD_EXPIRE, 1'b0, 8'h00, 16'h0000, 32'h0000_0001, 3'h0);
    endtask

    // Mostly completions that match a live tag, plus broken ones and noise.
    task automatic test_random_traffic(input int item_total);
        int               sent;
        int               pick;
        int               t;
        int               other;
        t_cmd             cmd;
        logic             sv;
        logic [SEG_W-1:0] seg;
        logic [RID_W-1:0] rid;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0] cc;
        sent = 0;
        while (sent < item_total) begin
            pick = $urandom_range(0, 99);
            cmd  = CMD_COMPL;
            sv   = 1'($urandom_range(0, 1));
            seg  = SEG_W'($urandom);
            rid  = RID_W'($urandom);
            mask = MASK_W'($urandom);
            cc   = CNT_W'($urandom);
            t    = find_tag(1'b1);
            if (pick < 20 || (pick < 80 && t < 0)) begin
                cmd = CMD_ALLOC;
            end else if (pick < 80) begin
                rid = shadow_requester[t];
                if (shadow_seg_valid[t]) begin
                    sv  = 1'b1;
                    seg = shadow_segment[t];
                end
                mask = MASK_W'(1) << t;
                if ($urandom_range(0, 1))
                    mask |= MASK_W'($urandom) & ~TAG_BITS;
                if ($urandom_range(0, 3) == 0)
                    mask |= MASK_W'($urandom) & TAG_BITS;
                if ($urandom_range(0, 1))
                    cc = shadow_count[t] + 1'b1;
                if (pick >= 70) begin
                    case ($urandom_range(0, 3))
                        0: rid ^= RID_W'(1) << $urandom_range(0, RID_W - 1);
                        1: begin
                            if (shadow_seg_valid[t])
                                seg ^= SEG_W'(1) << $urandom_range(0, SEG_W - 1);
                            else
                                rid = ~rid;
                        end
                        2: begin
                            if (shadow_seg_valid[t])
                                sv = 1'b0;
                            else
                                rid ^= RID_W'(1) << $urandom_range(0, RID_W - 1);
                        end
                        default: begin
                            other = find_tag(1'b0);
                            if (other >= 0)
                                mask = MASK_W'(1) << other;
                            else
                                rid = ~rid;
                        end
                    endcase
                end
            end else if (pick < 85) begin
                cmd = CMD_EXPIRE;
            end else if (pick < 90) begin
                cmd = CMD_NOP;
            end else begin
                cmd = t_cmd'($urandom_range(0, 3));
            end
            send_command(cmd, sv, seg, rid, mask, cc);
            if (cmd != CMD_NOP)
                sent++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_allocation();
        test_completion();
        test_unused_command();
        test_timer_expiry();
        test_random_traffic(400);
        wait_for_results();
        test_random_traffic(400);
        wait_for_results();
        repeat (NUM_TAGS + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("invalidation_tag_tracker_core_test OK");
        end else begin
            $display("invalidation_tag_tracker_core_test NOT OK");
        end
        $finish;
    end

    initial begin
        for (int t = 0; t < NUM_TAGS; t++) begin
            shadow_busy[t]      = 1'b0;
            shadow_seg_valid[t] = 1'b0;
            shadow_segment[t]   = '0;
            shadow_requester[t] = '0;
            shadow_count[t]     = '0;
        end
        shadow_timeout = 1'b0;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/itt_pkg.sv
rtl/itt_tag_check.sv
rtl/invalidation_tag_tracker_core.sv
bench/invalidation_tag_tracker_core_test.sv
